@@ hw/rtl/bfg_pkg.sv @@
// Shared types and constants for the battery fuel gauge.
// Holds the controller/datapath command and status structs and the LiPo cell table.
// No dependencies.
package bfg_pkg;

    // Operand set that the shared divider works on.
    typedef enum logic [1:0] {
        SEL_CUR  = 2'd0,
        SEL_MAH  = 2'd1,
        SEL_CELL = 2'd2,
        SEL_PCT  = 2'd3
    } t_div_sel;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIV_RATIO = 2'd0;
    localparam logic [1:0] REG_CELLS     = 2'd1;
    localparam logic [1:0] REG_SCALE     = 2'd2;
    localparam logic [1:0] REG_INTERVAL  = 2'd3;

    localparam int unsigned LUT_POINTS = 21;
    localparam logic [23:0] MAS_PER_MAH = 24'd3600000;
    localparam logic [13:0] MA_SCALE    = 14'd10000;

    // Consumed mAh is (accum >> 7) / 28125. The quotient comes from a multiply by the
    // rounded-up reciprocal 2^72 / 28125, exact for every 57-bit shifted accumulator.
    localparam logic [14:0] MAH_ODD   = 15'(MAS_PER_MAH >> 7);
    localparam logic [57:0] MAH_RECIP = 58'(((128'd1 << 72) + 128'(MAH_ODD) - 128'd1)
                                            / 128'(MAH_ODD));

    // Per-cell voltage breakpoints (mV) and their remaining percent.
    localparam logic [12:0] LUT_MV [LUT_POINTS] = '{
        13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3920,
        13'd3870, 13'd3830, 13'd3790, 13'd3750, 13'd3710, 13'd3680, 13'd3650,
        13'd3620, 13'd3580, 13'd3530, 13'd3490, 13'd3450, 13'd3400, 13'd3300
    };
    localparam logic [6:0] LUT_PCT [LUT_POINTS] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55,
        7'd50, 7'd45, 7'd40, 7'd35, 7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     in_take;
        logic     mul;
        logic     div_start;
        logic     div_cap;
        t_div_sel div_sel;
        logic     cur_zero;
        logic     chg_mul;
        logic     acc;
        logic     seg_ld;
        logic     pct_end;
        logic     pct_zero;
        logic     out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cal_done;
        logic scale_zero;
        logic cells_zero;
        logic div_done;
        logic seg_end;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/bfg_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
// The dividend is left aligned; nbits quotient bits land in the low bits of the result.
// No package dependencies.
module bfg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [23:0] i_divisor,
    input  logic [6:0]  i_nbits,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_q;
    logic [23:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] trial;
    logic        ge;

    // Trial subtraction of the next partial remainder.
    assign trial = {r_rem, r_q[63]};
    assign ge    = trial >= {1'b0, i_divisor};

    // Control: count remaining bits and flag the finish.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data: shift in quotient bits and update the remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], ge};
            r_rem <= ge ? 24'(trial - {1'b0, i_divisor}) : trial[23:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/bfg_dp.sv @@
// Datapath of the fuel gauge: configuration, calibration, products, accumulator and output.
// Uses bfg_pkg for command/status types and the cell table; instantiates bfg_div.
module bfg_dp #(
    parameter int CAL_SAMPLES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic [11:0]    i_vsense,
    input  logic [11:0]    i_isense,
    input  logic           i_out_ready,
    input  bfg_pkg::t_cmd  i_cmd,
    output bfg_pkg::t_sts  o_sts,
    output logic           o_out_valid,
    output logic [70:0]    o_out_data
);

    localparam int CW = $clog2(CAL_SAMPLES + 1);

    logic [15:0] r_ratio;
    logic [3:0]  r_cells;
    logic [15:0] r_scale;
    logic [15:0] r_interval;

    logic [CW-1:0] r_cal_cnt;
    logic [11:0]   r_cal_min;
    logic [11:0]   r_zero;
    logic [63:0]   r_accum;

    logic [11:0] r_v;
    logic [11:0] r_i;
    logic [19:0] r_pack;
    logic [25:0] r_prod;
    logic [25:0] r_cur;
    logic [41:0] r_add;
    logic [31:0] r_mah;
    logic [15:0] r_cell;
    logic [13:0] r_num;
    logic [6:0]  r_den;
    logic [6:0]  r_plo;
    logic [6:0]  r_pct;
    logic        r_ovalid;
    logic [70:0] r_odata;

    logic [56:0]  r_mq_n;
    logic [115:0] r_mq_acc;
    logic [1:0]   r_mq_step;
    logic         r_mq_busy;
    logic         r_mq_done;

    logic [11:0]  diff;
    logic [11:0]  n_cal_min;
    logic [64:0]  sum;
    logic [63:0]  dividend;
    logic [23:0]  divisor;
    logic [6:0]   nbits;
    logic         div_go;
    logic         div_done;
    logic [63:0]  quot;
    logic         mq_go;
    logic [28:0]  mq_a;
    logic [28:0]  mq_b;
    logic [57:0]  mq_pp;
    logic [115:0] mq_term;
    logic [4:0]   seg;
    logic [15:0]  seg_off;
    logic         cell_hi;
    logic         cell_lo;
    logic [15:0]  pack_sat;
    logic [15:0]  cur_sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio    <= 16'd256;
            r_cells    <= 4'd3;
            r_scale    <= 16'd400;
            r_interval <= 16'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfg_pkg::REG_DIV_RATIO: r_ratio    <= i_cfg_data;
                bfg_pkg::REG_CELLS:     r_cells    <= i_cfg_data[3:0];
                bfg_pkg::REG_SCALE:     r_scale    <= i_cfg_data;
                bfg_pkg::REG_INTERVAL:  r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Calibration tracks the smallest current sense and latches it as the offset.
    assign n_cal_min = (i_isense < r_cal_min) ? i_isense : r_cal_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_cnt <= '0;
            r_cal_min <= 12'hFFF;
            r_zero    <= '0;
        end else if (i_cmd.in_take && !o_sts.cal_done) begin
            r_cal_min <= n_cal_min;
            r_cal_cnt <= r_cal_cnt + CW'(1);
            if (r_cal_cnt + CW'(1) == CW'(CAL_SAMPLES)) begin
                r_zero <= n_cal_min;
            end
        end
    end

    // Charge accumulator saturates at all ones.
    assign sum = {1'b0, r_accum} + {23'd0, r_add};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_cmd.acc) begin
            r_accum <= sum[64] ? {64{1'b1}} : sum[63:0];
        end
    end

    // The mAh quotient uses the reciprocal unit; every other pass uses the divider.
    assign mq_go  = i_cmd.div_start && (i_cmd.div_sel == bfg_pkg::SEL_MAH);
    assign div_go = i_cmd.div_start && (i_cmd.div_sel != bfg_pkg::SEL_MAH);

    // Operand selection for the shared divider.
    always_comb begin
        case (i_cmd.div_sel)
            bfg_pkg::SEL_CUR: begin
                dividend = {r_prod, 38'd0};
                divisor  = {8'd0, r_scale};
                nbits    = 7'd26;
            end
            bfg_pkg::SEL_CELL: begin
                dividend = {r_pack, 44'd0};
                divisor  = {20'd0, r_cells};
                nbits    = 7'd20;
            end
            bfg_pkg::SEL_PCT: begin
                dividend = {r_num, 50'd0};
                divisor  = {17'd0, r_den};
                nbits    = 7'd14;
            end
            default: begin
                dividend = '0;
                divisor  = 24'd1;
                nbits    = 7'd1;
            end
        endcase
    end

    bfg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_nbits    (nbits),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Reciprocal unit: four 29x29 partial products of (accum >> 7) times the reciprocal.
    assign mq_a  = r_mq_step[1] ? {1'b0, r_mq_n[56:29]} : r_mq_n[28:0];
    assign mq_b  = r_mq_step[0] ? bfg_pkg::MAH_RECIP[57:29] : bfg_pkg::MAH_RECIP[28:0];
    assign mq_pp = mq_a * mq_b;

    always_comb begin
        case (r_mq_step)
            2'd0:    mq_term = {58'd0, mq_pp};
            2'd3:    mq_term = {mq_pp, 58'd0};
            default: mq_term = {29'd0, mq_pp, 29'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mq_busy <= 1'b0;
            r_mq_done <= 1'b0;
            r_mq_step <= '0;
        end else begin
            r_mq_done <= 1'b0;
            if (mq_go) begin
                r_mq_busy <= 1'b1;
                r_mq_step <= '0;
            end else if (r_mq_busy) begin
                r_mq_step <= r_mq_step + 2'd1;
                if (r_mq_step == 2'd3) begin
                    r_mq_busy <= 1'b0;
                    r_mq_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mq_go) begin
            r_mq_n   <= r_accum[63:7];
            r_mq_acc <= '0;
        end else if (r_mq_busy) begin
            r_mq_acc <= r_mq_acc + mq_term;
        end
    end

    // Table segment: the first breakpoint pair that brackets the cell voltage.
    always_comb begin
        seg = 5'd0;
        for (int k = int'(bfg_pkg::LUT_POINTS) - 2; k >= 0; k--) begin
            if (r_cell >= 16'(bfg_pkg::LUT_MV[k + 1])) begin
                seg = 5'(k);
            end
        end
    end

    assign seg_off = r_cell - 16'(bfg_pkg::LUT_MV[seg + 5'd1]);
    assign cell_hi = r_cell >= 16'(bfg_pkg::LUT_MV[0]);
    assign cell_lo = r_cell <= 16'(bfg_pkg::LUT_MV[bfg_pkg::LUT_POINTS - 1]);
    assign diff    = (r_i > r_zero) ? r_i - r_zero : 12'd0;

    // Sample capture, products and divider results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_v <= i_vsense;
            r_i <= i_isense;
        end
        if (i_cmd.mul) begin
            r_pack <= 20'((28'(r_v) * 28'(r_ratio)) >> 8);
            r_prod <= 26'(diff) * 26'(bfg_pkg::MA_SCALE);
        end
        if (i_cmd.cur_zero) begin
            r_cur <= '0;
        end
        if (i_cmd.chg_mul) begin
            r_add <= 42'(r_cur) * 42'(r_interval);
        end
        if (i_cmd.seg_ld) begin
            r_num <= 14'(seg_off[6:0]) *
                     14'(bfg_pkg::LUT_PCT[seg] - bfg_pkg::LUT_PCT[seg + 5'd1]);
            r_den <= 7'(bfg_pkg::LUT_MV[seg] - bfg_pkg::LUT_MV[seg + 5'd1]);
            r_plo <= bfg_pkg::LUT_PCT[seg + 5'd1];
        end
        if (i_cmd.pct_end) begin
            r_pct <= cell_hi ? 7'd100 : 7'd0;
        end
        if (i_cmd.pct_zero) begin
            r_pct <= '0;
        end
        if (i_cmd.div_cap) begin
            case (i_cmd.div_sel)
                bfg_pkg::SEL_CUR:  r_cur  <= quot[25:0];
                bfg_pkg::SEL_MAH:  r_mah  <= (r_mq_acc[115:104] != 12'd0) ? 32'hFFFF_FFFF
                                                                          : r_mq_acc[103:72];
                bfg_pkg::SEL_CELL: r_cell <= quot[15:0];
                bfg_pkg::SEL_PCT:  r_pct  <= r_plo + quot[6:0];
                default: ;
            endcase
        end
    end

    // Output register: holds a result until the output transaction completes.
    assign pack_sat = (r_pack[19:16] != 4'd0) ? 16'hFFFF : r_pack[15:0];
    assign cur_sat  = (r_cur[25:16] != 10'd0) ? 16'hFFFF : r_cur[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_odata <= {r_pct, r_mah, cur_sat, pack_sat};
        end
    end

    // Status toward the controller.
    assign o_sts.cal_done   = r_cal_cnt >= CW'(CAL_SAMPLES);
    assign o_sts.scale_zero = r_scale == 16'd0;
    assign o_sts.cells_zero = r_cells == 4'd0;
    assign o_sts.div_done   = div_done || r_mq_done;
    assign o_sts.seg_end    = cell_hi || cell_lo;
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

@@ hw/rtl/bfg_ctrl.sv @@
// Controller state machine that sequences one sample through the datapath.
// Uses bfg_pkg for the command and status structs.
module bfg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bfg_pkg::t_sts i_sts,
    output bfg_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_MUL     = 14'b00000000000010,
        S_CUR_GO  = 14'b00000000000100,
        S_CUR_W   = 14'b00000000001000,
        S_CHG_MUL = 14'b00000000010000,
        S_ACC     = 14'b00000000100000,
        S_MAH_GO  = 14'b00000001000000,
        S_MAH_W   = 14'b00000010000000,
        S_CELL_GO = 14'b00000100000000,
        S_CELL_W  = 14'b00001000000000,
        S_SEG     = 14'b00010000000000,
        S_PCT_GO  = 14'b00100000000000,
        S_PCT_W   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = bfg_pkg::SEL_CUR;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.in_take = i_in_valid;
                if (i_in_valid && i_sts.cal_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CUR_GO;
            end
            S_CUR_GO: begin
                if (i_sts.scale_zero) begin
                    o_cmd.cur_zero = 1'b1;
                    n_state        = S_CHG_MUL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_CUR_W;
                end
            end
            S_CUR_W: begin
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_CHG_MUL;
                end
            end
            S_CHG_MUL: begin
                o_cmd.chg_mul = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_MAH_GO;
            end
            S_MAH_GO: begin
                o_cmd.div_sel   = bfg_pkg::SEL_MAH;
                o_cmd.div_start = 1'b1;
                n_state         = S_MAH_W;
            end
            S_MAH_W: begin
                o_cmd.div_sel = bfg_pkg::SEL_MAH;
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_CELL_GO;
                end
            end
            S_CELL_GO: begin
                o_cmd.div_sel = bfg_pkg::SEL_CELL;
                if (i_sts.cells_zero) begin
                    o_cmd.pct_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_CELL_W;
                end
            end
            S_CELL_W: begin
                o_cmd.div_sel = bfg_pkg::SEL_CELL;
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_SEG;
                end
            end
            S_SEG: begin
                if (i_sts.seg_end) begin
                    o_cmd.pct_end = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.seg_ld = 1'b1;
                    n_state      = S_PCT_GO;
                end
            end
            S_PCT_GO: begin
                o_cmd.div_sel   = bfg_pkg::SEL_PCT;
                o_cmd.div_start = 1'b1;
                n_state         = S_PCT_W;
            end
            S_PCT_W: begin
                o_cmd.div_sel = bfg_pkg::SEL_PCT;
                if (i_sts.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/battery_fuel_gauge_top.sv @@
// Battery fuel gauge: coulomb counter with a LiPo per-cell voltage table.
// Calibration samples are accepted back to back and give no result.
// A measured sample passes through 26, 20 and 14 bit one-bit-per-cycle divides and a four-step
// mAh multiply; zero scale, zero cells or a table end skip passes. The next sample is taken only
// after its result is loaded into the output register, which waits while an older result stalls.
// Synchronous active-low reset restores defaults, restarts calibration and clears the charge.
module battery_fuel_gauge_top #(
    parameter int CAL_SAMPLES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] voltage_sense_mv, [23:12] current_sense_mv
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] pack_mv, [31:16] load_ma, [63:32] used_mah, [70:64] charge_left_pct, [71] zero
    output logic [71:0] m_axis_tdata
);

    bfg_pkg::t_cmd cmd;
    bfg_pkg::t_sts sts;
    logic [70:0]   out_data;

    bfg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfg_dp #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_vsense    (s_axis_tdata[11:0]),
        .i_isense    (s_axis_tdata[23:12]),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};

endmodule

@@ hw/rtl/bfg_checker.sv @@
// Port-level checker for the battery fuel gauge, bound to the top level.
// Depends only on the top level's ports.
module bfg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // Reset leaves no result pending.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Reset returns the block to taking samples.
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Remaining percent never exceeds 100 and the pad bit stays zero.
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'd100 && !m_axis_tdata[71])
        else $error("percent out of range");

endmodule

bind battery_fuel_gauge_top bfg_checker u_bfg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_battery_fuel_gauge_top.sv @@
// Self-checking testbench for the battery fuel gauge top level.
// Drives sense-voltage samples as stream transactions, predicts each result in a
// local gauge model and checks the outputs; depends on bfg_pkg and battery_fuel_gauge_top.
module tb_battery_fuel_gauge_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAL_N = 16;

    // Fields listed from the highest bits down to match the stream packing.
    typedef struct packed {
        logic [11:0] curr_mv;
        logic [11:0] volt_mv;
    } t_sample;

    typedef struct packed {
        logic [6:0]  pct;
        logic [31:0] used_mah;
        logic [15:0] load_ma;
        logic [15:0] pack_mv;
    } t_gauge;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [11:0] voltage_sense_mv, [23:12] current_sense_mv
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] pack_mv, [31:16] load_ma, [63:32] used_mah, [70:64] charge_left_pct, [71] zero
    logic [71:0] m_axis_tdata;

    battery_fuel_gauge_top #(.CAL_SAMPLES(CAL_N)) i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Model copy of the registers and the gauge state.
    logic [15:0] mdl_ratio = 16'd256;
    logic [3:0]  mdl_cells = 4'd3;
    logic [15:0] mdl_scale = 16'd400;
    logic [15:0] mdl_interval = 16'd100;
    int unsigned cal_seen = 0;
    logic [11:0] cal_low = 12'hFFF;
    logic [11:0] offset_mv = '0;
    logic [63:0] charge_mams = '0;

    t_sample sample_q[$];
    t_gauge  gauge_q[$];
    int      errors = 0;
    int      results_seen = 0;
    bit      steady = 1'b0;
    int      hold_cycles = 0;
    bit      hold_done = 1'b0;

    // Remaining percent from the per-cell table.
    function automatic logic [6:0] cell_pct(logic [20:0] pack_full);
        logic [15:0] cell_mv;
        int lo_v, hi_v, lo_p, hi_p;
        if (mdl_cells == 0) return 7'd0;
        cell_mv = 16'(pack_full / mdl_cells);
        if (cell_mv >= bfg_pkg::LUT_MV[0]) return 7'd100;
        if (cell_mv <= bfg_pkg::LUT_MV[bfg_pkg::LUT_POINTS-1]) return 7'd0;
        for (int k = 0; k < bfg_pkg::LUT_POINTS - 1; k++) begin
            if (cell_mv >= bfg_pkg::LUT_MV[k+1]) begin
                hi_v = bfg_pkg::LUT_MV[k];
                lo_v = bfg_pkg::LUT_MV[k+1];
                hi_p = bfg_pkg::LUT_PCT[k];
                lo_p = bfg_pkg::LUT_PCT[k+1];
                return 7'(lo_p + (int'(cell_mv) - lo_v) * (hi_p - lo_p) / (hi_v - lo_v));
            end
        end
        return 7'd0;
    endfunction

    // Update the gauge state for one accepted sample and queue its result, if any.
    task automatic gauge_update(t_sample smp);
        logic [20:0] pack_full;
        logic [25:0] cur_full;
        logic [11:0] diff;
        logic [63:0] add, mah;
        t_gauge g;
        if (cal_seen < CAL_N) begin
            if (smp.curr_mv < cal_low) cal_low = smp.curr_mv;
            cal_seen++;
            if (cal_seen == CAL_N) offset_mv = cal_low;
            return;
        end
        pack_full = 21'((33'(smp.volt_mv) * mdl_ratio) >> 8);
        cur_full = '0;
        if (mdl_scale != 0) begin
            diff = (smp.curr_mv > offset_mv) ? smp.curr_mv - offset_mv : 12'd0;
            cur_full = 26'((40'(diff) * 10000) / mdl_scale);
        end
        add = 64'(cur_full) * mdl_interval;
        if (charge_mams > 64'hFFFF_FFFF_FFFF_FFFF - add)
            charge_mams = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            charge_mams = charge_mams + add;
        mah = charge_mams / 64'd3600000;
        g.pack_mv = (pack_full > 21'hFFFF) ? 16'hFFFF : pack_full[15:0];
        g.load_ma = (cur_full > 26'hFFFF) ? 16'hFFFF : cur_full[15:0];
        g.used_mah = (mah > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mah[31:0];
        g.pct = cell_pct(pack_full);
        gauge_q.push_back(g);
    endtask

    // Sample driver: updates the model on each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) gauge_update(t_sample'(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() > 0 && (steady || $urandom_range(0, 99) >= 7)) begin
                    s_axis_tdata <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once after the sixtieth result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && results_seen >= 60) begin
            hold_cycles <= 1500;
            hold_done <= 1'b1;
        end
    end

    // Result monitor with random stalls.
    always @(posedge i_clk) begin
        t_gauge got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_gauge'(m_axis_tdata[70:0]);
                results_seen++;
                if (gauge_q.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = gauge_q.pop_front();
                    if (got.pack_mv !== want.pack_mv) begin
                        $error("pack_mv exp %0d got %0d", want.pack_mv, got.pack_mv);
                        errors++;
                    end
                    if (got.load_ma !== want.load_ma) begin
                        $error("load_ma exp %0d got %0d", want.load_ma, got.load_ma);
                        errors++;
                    end
                    if (got.used_mah !== want.used_mah) begin
                        $error("used_mah exp %0d got %0d", want.used_mah, got.used_mah);
                        errors++;
                    end
                    if (got.pct !== want.pct) begin
                        $error("charge_left_pct exp %0d got %0d", want.pct, got.pct);
                        errors++;
                    end
                    if (m_axis_tdata[71] !== 1'b0) begin
                        $error("pad bit exp 0 got %b", m_axis_tdata[71]);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bfg_pkg::REG_DIV_RATIO: mdl_ratio = val;
            bfg_pkg::REG_CELLS:     mdl_cells = val[3:0];
            bfg_pkg::REG_SCALE:     mdl_scale = val;
            default:                mdl_interval = val;
        endcase
    endtask

    // Wait for the block to drain, plus its longest internal latency.
    task automatic drain();
        while (sample_q.size() > 0 || s_axis_tvalid || gauge_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic push_sample(int v, int c);
        t_sample s;
        s.volt_mv = 12'(v);
        s.curr_mv = 12'(c);
        sample_q.push_back(s);
    endtask

    // Register settings per phase: ratio, cells, scale, interval.
    int phase_cfg[8][4] = '{
        '{1280, 3, 400, 100},
        '{0, 0, 0, 0},
        '{65535, 15, 65535, 65535},
        '{3840, 1, 1, 1},
        '{768, 4, 2000, 65535},
        '{2560, 6, 50, 1000},
        '{1024, 15, 10, 500},
        '{5120, 2, 400, 20}
    };

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Calibration samples; the minimum current sense becomes the offset.
        for (int k = 0; k < CAL_N; k++)
            push_sample($urandom_range(0, 4095), (k == 5) ? 150 : $urandom_range(151, 4095));
        // Field extremes and the offset clamp at reset settings.
        push_sample(0, 0);
        push_sample(4095, 4095);
        push_sample(4095, 0);
        push_sample(0, 4095);
        push_sample(2048, 150);
        push_sample(1365, 149);
        push_sample(2730, 151);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(bfg_pkg::REG_DIV_RATIO, 16'(phase_cfg[ph][0]));
            reg_write(bfg_pkg::REG_CELLS, 16'(phase_cfg[ph][1]));
            reg_write(bfg_pkg::REG_SCALE, 16'(phase_cfg[ph][2]));
            reg_write(bfg_pkg::REG_INTERVAL, 16'(phase_cfg[ph][3]));
            steady = (ph == 3);
            if (ph == 0) begin
                // Table ends and breakpoints at 5x divider, 3 cells.
                push_sample(2520, 300);
                push_sample(2521, 300);
                push_sample(1980, 300);
                push_sample(1981, 300);
                push_sample(2250, 300);
                push_sample(2200, 300);
            end
            for (int n = 0; n < 225; n++) begin
                if ($urandom_range(0, 3) == 0)
                    push_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
                else if (mdl_cells != 0 && mdl_ratio != 0)
                    // Aim the cell voltage into the table range.
                    push_sample(int'((longint'($urandom_range(3250, 4250)) * mdl_cells * 256)
                                / mdl_ratio) % 4096, $urandom_range(100, 600));
                else
                    push_sample($urandom_range(0, 4095), $urandom_range(0, 800));
            end
            drain();
        end

        if (errors == 0) begin
            $display("battery_fuel_gauge_top test passed");
        end else begin
            $display("battery_fuel_gauge_top test failed");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #40_000_000;
        $display("battery_fuel_gauge_top test failed");
        $finish;
    end

endmodule
